### sv/mtep_pkg.sv
// types and constants shared by the track event parser modules
package mtep_pkg;

	localparam int unsigned DELTA_W = 28;
	localparam logic [2:0] MAX_DELTA_BYTES = 3'd4;

	localparam logic [7:0] STATUS_META = 8'hFF;
	localparam logic [7:0] STATUS_SYS_FIRST = 8'hF0;
	localparam logic [3:0] TYPE_PROG_CHANGE = 4'hC;
	localparam logic [3:0] TYPE_CHAN_PRESSURE = 4'hD;
	localparam logic [7:0] META_SEQ_NUMBER = 8'h00;
	localparam logic [7:0] META_TEXT_FIRST = 8'h01;
	localparam logic [7:0] META_TEXT_LAST = 8'h07;

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_CH_P1,
		PH_CH_P2,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_DATA,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHANNEL,
		KIND_META_DONE,
		KIND_META_TEXT,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_BAD_STATUS,
		ERR_DELTA_LONG
	} err_t;

	typedef struct packed {
		kind_t              result_kind;
		err_t               error_code;
		logic [DELTA_W-1:0] delta_ticks;
		logic [3:0]         event_type;
		logic [3:0]         channel;
		logic [7:0]         param1;
		logic [7:0]         param2;
		logic [7:0]         meta_type;
		logic [7:0]         text_byte;
	} result_t;

endpackage

### sv/mtep_in_stage.sv
// input register stage holding one track byte word
module mtep_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       track_start,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] data_s1,
	output logic       start_s1
);

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= data_byte;
			start_s1 <= track_start;
		end
	end

endmodule

### sv/mtep_core.sv
// parser state and per-byte decode of track events
module mtep_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_s1,
	input  logic             start_s1,
	output logic             res_valid,
	output mtep_pkg::result_t res
);

	mtep_pkg::phase_t phase_q, phase_d, ph;
	logic [mtep_pkg::DELTA_W-1:0] acc_q, acc_d, acc;
	logic [2:0] cnt_q, cnt_d, cnt;
	logic [7:0] status_q, status_d;
	logic [7:0] fp_q, fp_d;
	logic [7:0] sp_q, sp_d;
	logic [7:0] mkind_q, mkind_d;
	logic [7:0] left_q, left_d;
	logic [7:0] pos_q, pos_d;
	logic       is_text;

	assign is_text = (mkind_q >= mtep_pkg::META_TEXT_FIRST) &&
		(mkind_q <= mtep_pkg::META_TEXT_LAST);

	always_comb begin
		ph = start_s1 ? mtep_pkg::PH_DELTA : phase_q;
		acc = start_s1 ? '0 : acc_q;
		cnt = start_s1 ? 3'd0 : cnt_q;
		phase_d = ph;
		acc_d = acc;
		cnt_d = cnt;
		status_d = status_q;
		fp_d = fp_q;
		sp_d = sp_q;
		mkind_d = mkind_q;
		left_d = left_q;
		pos_d = pos_q;
		res_valid = 1'b0;
		res = '0;
		res.delta_ticks = acc;
		case (ph)
			mtep_pkg::PH_DELTA: begin
				acc_d = {acc[mtep_pkg::DELTA_W-8:0], data_s1[6:0]};
				cnt_d = cnt + 3'd1;
				if (data_s1[7]) begin
					if (cnt_d >= mtep_pkg::MAX_DELTA_BYTES) begin
						res_valid = 1'b1;
						res.result_kind = mtep_pkg::KIND_ERROR;
						res.error_code = mtep_pkg::ERR_DELTA_LONG;
						res.delta_ticks = acc_d;
						phase_d = mtep_pkg::PH_ERROR;
					end
				end else begin
					phase_d = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (data_s1 == mtep_pkg::STATUS_META) begin
					phase_d = mtep_pkg::PH_META_TYPE;
				end else if (!data_s1[7] || data_s1 >= mtep_pkg::STATUS_SYS_FIRST) begin
					res_valid = 1'b1;
					res.result_kind = mtep_pkg::KIND_ERROR;
					res.error_code = mtep_pkg::ERR_BAD_STATUS;
					phase_d = mtep_pkg::PH_ERROR;
				end else begin
					status_d = data_s1;
					phase_d = mtep_pkg::PH_CH_P1;
				end
			end
			mtep_pkg::PH_CH_P1: begin
				fp_d = data_s1;
				if (status_q[7:4] == mtep_pkg::TYPE_PROG_CHANGE ||
					status_q[7:4] == mtep_pkg::TYPE_CHAN_PRESSURE) begin
					res_valid = 1'b1;
					res.result_kind = mtep_pkg::KIND_CHANNEL;
					res.event_type = status_q[7:4];
					res.channel = status_q[3:0];
					res.param1 = data_s1;
					phase_d = mtep_pkg::PH_DELTA;
					acc_d = '0;
					cnt_d = 3'd0;
				end else begin
					phase_d = mtep_pkg::PH_CH_P2;
				end
			end
			mtep_pkg::PH_CH_P2: begin
				res_valid = 1'b1;
				res.result_kind = mtep_pkg::KIND_CHANNEL;
				res.event_type = status_q[7:4];
				res.channel = status_q[3:0];
				res.param1 = fp_q;
				res.param2 = data_s1;
				phase_d = mtep_pkg::PH_DELTA;
				acc_d = '0;
				cnt_d = 3'd0;
			end
			mtep_pkg::PH_META_TYPE: begin
				mkind_d = data_s1;
				phase_d = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				left_d = data_s1;
				pos_d = 8'd0;
				fp_d = 8'd0;
				sp_d = 8'd0;
				if (data_s1 == 8'd0) begin
					res_valid = 1'b1;
					res.result_kind = mtep_pkg::KIND_META_DONE;
					res.meta_type = mkind_q;
					phase_d = mtep_pkg::PH_DELTA;
					acc_d = '0;
					cnt_d = 3'd0;
				end else begin
					phase_d = mtep_pkg::PH_META_DATA;
				end
			end
			mtep_pkg::PH_META_DATA: begin
				if (pos_q == 8'd0) begin
					fp_d = data_s1;
				end else if (pos_q == 8'd1) begin
					sp_d = data_s1;
				end
				pos_d = pos_q + 8'd1;
				left_d = left_q - 8'd1;
				if (is_text) begin
					res_valid = 1'b1;
					res.result_kind = mtep_pkg::KIND_META_TEXT;
					res.meta_type = mkind_q;
					res.text_byte = data_s1;
					if (left_d == 8'd0) begin
						phase_d = mtep_pkg::PH_DELTA;
						acc_d = '0;
						cnt_d = 3'd0;
					end
				end else if (left_d == 8'd0) begin
					res_valid = 1'b1;
					res.result_kind = mtep_pkg::KIND_META_DONE;
					res.meta_type = mkind_q;
					if (mkind_q == mtep_pkg::META_SEQ_NUMBER) begin
						res.param1 = fp_d;
						res.param2 = sp_d;
					end
					phase_d = mtep_pkg::PH_DELTA;
					acc_d = '0;
					cnt_d = 3'd0;
				end
			end
			mtep_pkg::PH_ERROR: begin
				phase_d = mtep_pkg::PH_ERROR;
			end
			default: begin
				phase_d = mtep_pkg::PH_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_DELTA;
			acc_q <= '0;
			cnt_q <= 3'd0;
			status_q <= 8'd0;
			fp_q <= 8'd0;
			sp_q <= 8'd0;
			mkind_q <= 8'd0;
			left_q <= 8'd0;
			pos_q <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			status_q <= status_d;
			fp_q <= fp_d;
			sp_q <= sp_d;
			mkind_q <= mkind_d;
			left_q <= left_d;
			pos_q <= pos_d;
		end
	end

	a_error_parks: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_valid && res.result_kind == mtep_pkg::KIND_ERROR
		|=> phase_q == mtep_pkg::PH_ERROR)
		else $error("error word did not park the parser");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == mtep_pkg::PH_ERROR && !start_s1 |-> !res_valid)
		else $error("word produced while waiting for track start");

	a_channel_type: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_valid && res.result_kind == mtep_pkg::KIND_CHANNEL
		|-> res.event_type >= 4'h8 && res.event_type <= 4'hE)
		else $error("channel event with non-channel type");

endmodule

### sv/mtep_out_stage.sv
// result register towards the output channel
module mtep_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              res_valid,
	input  mtep_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output mtep_pkg::result_t res_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

### sv/midi_track_event_parser_unit.sv
// top level of the midi track event parser
// Parses a track chunk body one byte word per cycle: variable-length delta
// times of up to four bytes, channel events, and meta events whose data is
// skipped, with text meta characters and sequence numbers reported. One byte
// is accepted every cycle while the result side keeps up; a byte passes an
// input register, is decoded by a single state machine step and its result,
// if any, lands in the result register, so a result is presented on the cycle
// after its byte is taken. A bad status byte or an over-long delta time gives
// an error word, after which bytes are swallowed until one with track_start set.
module midi_track_event_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [1:0]  error_code,
	output logic [27:0] delta_ticks,
	output logic [3:0]  event_type,
	output logic [3:0]  channel,
	output logic [7:0]  param1,
	output logic [7:0]  param2,
	output logic [7:0]  meta_type,
	output logic [7:0]  text_byte
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              start_s1;
	logic              take;
	logic              res_valid;
	mtep_pkg::result_t res;
	mtep_pkg::result_t res_s2;

	assign take = valid_s1 && (!out_valid || out_ready);

	mtep_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.track_start (track_start),
		.take        (take),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1),
		.start_s1    (start_s1)
	);

	mtep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_s1   (data_s1),
		.start_s1  (start_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mtep_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign result_kind = res_s2.result_kind;
	assign error_code = res_s2.error_code;
	assign delta_ticks = res_s2.delta_ticks;
	assign event_type = res_s2.event_type;
	assign channel = res_s2.channel;
	assign param1 = res_s2.param1;
	assign param2 = res_s2.param2;
	assign meta_type = res_s2.meta_type;
	assign text_byte = res_s2.text_byte;

endmodule
